// ----- hw/rtl/bmec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmec_pkg
// Shared codes and fixed field widths of the 5x5 box-mean core.
// ----------------------------------------------------------------------------
package bmec_pkg;

   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int CSR_W  = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [CSR_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [CSR_W-1:0] RESET_HEIGHT = 12'd480;

endpackage

// ----- hw/rtl/bmec_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmec_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmec_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 12288
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bmec_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmec_fifo
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module bmec_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

// ----- hw/rtl/bmec_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmec_front
// Takes input transactions, stores pixels in the row store, tracks input and
// output positions and queues one job per due output pixel.
// ----------------------------------------------------------------------------
module bmec_front import bmec_pkg::*; #(
   parameter int MAX_WIDTH     = 2048,
   parameter int MAX_HEIGHT    = 2048,
   parameter int WINDOW_RADIUS = 2,
   localparam int CLW   = $clog2(MAX_WIDTH + 1),
   localparam int HW    = $clog2(MAX_HEIGHT + WINDOW_RADIUS + 2),
   localparam int DEPTH = (2 * WINDOW_RADIUS + 2) * MAX_WIDTH,
   localparam int AW    = $clog2(DEPTH),
   localparam int LAGW  = $clog2(WINDOW_RADIUS * MAX_WIDTH + WINDOW_RADIUS + 1),
   localparam int JW    = HW + CLW + AW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [CLW-1:0]    width,
   input  logic [HW-1:0]     height,
   input  logic [LAGW-1:0]   lag,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [CHAN_W-1:0] req_pixel_red,
   input  logic [CHAN_W-1:0] req_pixel_green,
   input  logic [CHAN_W-1:0] req_pixel_blue,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [PIX_W-1:0]  wr_data,
   output logic              job_push,
   output logic [JW-1:0]     job_data,
   input  logic              job_full,
   input  logic              drained
);

   logic [HW-1:0]   in_row_ff, in_row_in;
   logic [CLW-1:0]  in_col_ff, in_col_in;
   logic [AW-1:0]   in_addr_ff, in_addr_in;
   logic [LAGW-1:0] lag_cnt_ff, lag_cnt_in;
   logic [HW-1:0]   out_row_ff, out_row_in;
   logic [CLW-1:0]  out_col_ff, out_col_in;
   logic [AW-1:0]   out_addr_ff, out_addr_in;
   logic            flush_ff, flush_in;
   logic            accept;
   logic            due;
   logic            last;

   assign req_stall = job_full || flush_ff;
   assign accept    = req_valid && !req_stall;
   assign due       = (lag_cnt_ff >= lag);
   assign last      = (out_row_ff == height - 1'b1) && (out_col_ff == width - 1'b1);

   assign wr_en    = accept && (in_row_ff < height);
   assign wr_addr  = in_addr_ff;
   assign wr_data  = (req_operation == OP_DRAIN) ? '0
                   : {req_pixel_red, req_pixel_green, req_pixel_blue};
   assign job_push = accept && due;
   assign job_data = {out_row_ff, out_col_ff, out_addr_ff, last};

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_addr_in  = in_addr_ff;
      lag_cnt_in  = lag_cnt_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_addr_in = out_addr_ff;
      flush_in    = flush_ff;
      if (job_push && last) begin
         flush_in = 1'b1;
      end else if (drained) begin
         flush_in = 1'b0;
      end
      if (restart || (job_push && last)) begin
         in_row_in   = '0;
         in_col_in   = '0;
         in_addr_in  = '0;
         lag_cnt_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_addr_in = '0;
      end else if (accept) begin
         if ({1'b0, in_col_ff} + 1'b1 >= {1'b0, width}) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         in_addr_in = (in_addr_ff == AW'(DEPTH - 1)) ? '0 : in_addr_ff + 1'b1;
         if (!due) begin
            lag_cnt_in = lag_cnt_ff + 1'b1;
         end else begin
            if ({1'b0, out_col_ff} + 1'b1 >= {1'b0, width}) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
            out_addr_in = (out_addr_ff == AW'(DEPTH - 1)) ? '0 : out_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_addr_ff  <= '0;
         lag_cnt_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_addr_ff <= '0;
         flush_ff    <= 1'b0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_addr_ff  <= in_addr_in;
         lag_cnt_ff  <= lag_cnt_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_addr_ff <= out_addr_in;
         flush_ff    <= flush_in;
      end
   end

endmodule

// ----- hw/rtl/bmec_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmec_back
// Walks the window of one queued job through the row store, sums the inside
// neighbours, divides by their count one quotient bit a cycle and holds the
// result for the output channel.
// ----------------------------------------------------------------------------
module bmec_back import bmec_pkg::*; #(
   parameter int MAX_WIDTH     = 2048,
   parameter int MAX_HEIGHT    = 2048,
   parameter int WINDOW_RADIUS = 2,
   localparam int CLW   = $clog2(MAX_WIDTH + 1),
   localparam int HW    = $clog2(MAX_HEIGHT + WINDOW_RADIUS + 2),
   localparam int DEPTH = (2 * WINDOW_RADIUS + 2) * MAX_WIDTH,
   localparam int AW    = $clog2(DEPTH),
   localparam int LAGW  = $clog2(WINDOW_RADIUS * MAX_WIDTH + WINDOW_RADIUS + 1),
   localparam int JW    = HW + CLW + AW + 1,
   localparam int TAPS  = (2 * WINDOW_RADIUS + 1) * (2 * WINDOW_RADIUS + 1),
   localparam int CNTW  = $clog2(TAPS + 1),
   localparam int SW    = $clog2(TAPS * 255 + 1),
   localparam int RW    = $clog2(WINDOW_RADIUS + 1) + 1,
   localparam int XW    = HW + 2,
   localparam int YW    = CLW + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CLW-1:0]    width,
   input  logic [HW-1:0]     height,
   input  logic [LAGW-1:0]   lag,
   input  logic              job_empty,
   input  logic [JW-1:0]     job_data,
   output logic              job_pop,
   output logic              idle,
   output logic [AW-1:0]     rd_addr,
   input  logic [PIX_W-1:0]  rd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAN_W-1:0] rsp_mean_red,
   output logic [CHAN_W-1:0] rsp_mean_green,
   output logic [CHAN_W-1:0] rsp_mean_blue,
   output logic              rsp_frame_last
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_FIN,
      B_DIV,
      B_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [HW-1:0]        row_ff, row_in;
   logic [CLW-1:0]       col_ff, col_in;
   logic                 last_ff, last_in;
   logic signed [RW-1:0] dr_ff, dr_in;
   logic signed [RW-1:0] dc_ff, dc_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 pend_ff, pend_in;
   logic [SW-1:0]        sum_r_ff, sum_r_in;
   logic [SW-1:0]        sum_g_ff, sum_g_in;
   logic [SW-1:0]        sum_b_ff, sum_b_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [2:0]           bit_ff, bit_in;
   logic [CHAN_W-1:0]    q_r_ff, q_r_in;
   logic [CHAN_W-1:0]    q_g_ff, q_g_in;
   logic [CHAN_W-1:0]    q_b_ff, q_b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]    rsp_r_ff, rsp_r_in;
   logic [CHAN_W-1:0]    rsp_g_ff, rsp_g_in;
   logic [CHAN_W-1:0]    rsp_b_ff, rsp_b_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [HW-1:0]        j_row;
   logic [CLW-1:0]       j_col;
   logic [AW-1:0]        j_addr;
   logic                 j_last;
   logic [AW:0]          base_sum;
   logic [AW:0]          step_a;
   logic [AW:0]          step_b;
   logic [AW:0]          step_one;
   logic signed [XW-1:0] xs;
   logic signed [YW-1:0] ys;
   logic                 in_frame;
   logic [SW-1:0]        dvs;

   assign {j_row, j_col, j_addr, j_last} = job_data;

   assign xs = $signed({2'b00, row_ff}) + XW'(dr_ff);
   assign ys = $signed({2'b00, col_ff}) + YW'(dc_ff);
   assign in_frame = (xs >= 0) && (xs < $signed({2'b00, height}))
                  && (ys >= 0) && (ys < $signed({2'b00, width}));

   assign dvs = SW'(cnt_ff) << bit_ff;

   always_comb begin
      if ({1'b0, j_addr} >= (AW+1)'(lag)) begin
         base_sum = {1'b0, j_addr} - (AW+1)'(lag);
      end else begin
         base_sum = {1'b0, j_addr} + (AW+1)'(DEPTH) - (AW+1)'(lag);
      end
      step_one = {1'b0, addr_ff} + 1'b1;
      if (step_one >= (AW+1)'(DEPTH)) begin
         step_one = step_one - (AW+1)'(DEPTH);
      end
      step_a = {1'b0, addr_ff} + (AW+1)'(width);
      if (step_a >= (AW+1)'(DEPTH)) begin
         step_a = step_a - (AW+1)'(DEPTH);
      end
      if (step_a >= (AW+1)'(2 * WINDOW_RADIUS)) begin
         step_b = step_a - (AW+1)'(2 * WINDOW_RADIUS);
      end else begin
         step_b = step_a + (AW+1)'(DEPTH) - (AW+1)'(2 * WINDOW_RADIUS);
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      last_in      = last_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      sum_r_in     = sum_r_ff;
      sum_g_in     = sum_g_ff;
      sum_b_in     = sum_b_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      q_r_in       = q_r_ff;
      q_g_in       = q_g_ff;
      q_b_in       = q_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_last_in  = rsp_last_ff;
      job_pop      = 1'b0;

      if (pend_ff) begin
         sum_r_in = sum_r_ff + SW'(rd_data[3*CHAN_W-1:2*CHAN_W]);
         sum_g_in = sum_g_ff + SW'(rd_data[2*CHAN_W-1:CHAN_W]);
         sum_b_in = sum_b_ff + SW'(rd_data[CHAN_W-1:0]);
         cnt_in   = cnt_ff + 1'b1;
      end

      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               row_in   = j_row;
               col_in   = j_col;
               last_in  = j_last;
               dr_in    = -RW'(WINDOW_RADIUS);
               dc_in    = -RW'(WINDOW_RADIUS);
               addr_in  = base_sum[AW-1:0];
               sum_r_in = '0;
               sum_g_in = '0;
               sum_b_in = '0;
               cnt_in   = '0;
               state_in = B_READ;
            end
         end
         B_READ: begin
            pend_in = in_frame;
            if (dc_ff == RW'(WINDOW_RADIUS)) begin
               dc_in   = -RW'(WINDOW_RADIUS);
               dr_in   = dr_ff + 1'b1;
               addr_in = step_b[AW-1:0];
               if (dr_ff == RW'(WINDOW_RADIUS)) begin
                  state_in = B_FIN;
               end
            end else begin
               dc_in   = dc_ff + 1'b1;
               addr_in = step_one[AW-1:0];
            end
         end
         B_FIN: begin
            bit_in   = 3'd7;
            q_r_in   = '0;
            q_g_in   = '0;
            q_b_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            if (sum_r_ff >= dvs) begin
               sum_r_in = sum_r_ff - dvs;
               q_r_in[bit_ff] = 1'b1;
            end
            if (sum_g_ff >= dvs) begin
               sum_g_in = sum_g_ff - dvs;
               q_g_in[bit_ff] = 1'b1;
            end
            if (sum_b_ff >= dvs) begin
               sum_b_in = sum_b_ff - dvs;
               q_b_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 3'd0) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_r_in     = q_r_ff;
               rsp_g_in     = q_g_ff;
               rsp_b_in     = q_b_ff;
               rsp_last_in  = last_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      last_ff     <= last_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      addr_ff     <= addr_in;
      sum_r_ff    <= sum_r_in;
      sum_g_ff    <= sum_g_in;
      sum_b_ff    <= sum_b_in;
      cnt_ff      <= cnt_in;
      bit_ff      <= bit_in;
      q_r_ff      <= q_r_in;
      q_g_ff      <= q_g_in;
      q_b_ff      <= q_b_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_g_ff    <= rsp_g_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign idle           = (state_ff == B_IDLE);
   assign rd_addr        = addr_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_red   = rsp_r_ff;
   assign rsp_mean_green = rsp_g_ff;
   assign rsp_mean_blue  = rsp_b_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// ----- hw/rtl/box_mean_5x5_edge_clipped_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_mean_5x5_edge_clipped_core
// Streaming RGB box-mean blur with edge-clipped divisor.
// Result path: a transaction that yields a result queues a job; the back part
//   takes it once idle, walks the window, divides and registers the mean, so
//   any output stall and any jobs queued ahead delay the result.
// Throughput: the back part takes no new job until its result is registered;
//   the window walk uses the single read port of the row store. Transactions
//   without a result are taken one per cycle while the two-entry job queue has
//   room, and the first transaction of a new frame waits for the back to drain.
// Reset: positions cleared, width 640, height 480; row store is not cleared.
// ----------------------------------------------------------------------------
module box_mean_5x5_edge_clipped_core import bmec_pkg::*; #(
   parameter int MAX_WIDTH     = 2048,
   parameter int MAX_HEIGHT    = 2048,
   parameter int WINDOW_RADIUS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [CHAN_W-1:0]    req_pixel_red,
   input  logic [CHAN_W-1:0]    req_pixel_green,
   input  logic [CHAN_W-1:0]    req_pixel_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_W-1:0]    rsp_mean_red,
   output logic [CHAN_W-1:0]    rsp_mean_green,
   output logic [CHAN_W-1:0]    rsp_mean_blue,
   output logic                 rsp_frame_last
);

   localparam int CLW   = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + WINDOW_RADIUS + 2);
   localparam int DEPTH = (2 * WINDOW_RADIUS + 2) * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int LAGW  = $clog2(WINDOW_RADIUS * MAX_WIDTH + WINDOW_RADIUS + 1);
   localparam int JW    = HW + CLW + AW + 1;

   logic [CSR_W-1:0] width_cfg_ff, width_cfg_in;
   logic [CSR_W-1:0] height_cfg_ff, height_cfg_in;
   logic             restart;
   logic [CLW-1:0]   width_eff;
   logic [HW-1:0]    height_eff;
   logic [LAGW-1:0]  lag;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [PIX_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic             job_push;
   logic [JW-1:0]    job_push_data;
   logic             job_pop;
   logic [JW-1:0]    job_pop_data;
   logic             job_full;
   logic             job_empty;
   logic             back_idle;
   logic             drained;

   assign restart = csr_we
                 && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   assign drained = job_empty && back_idle;

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_cfg_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_cfg_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= RESET_WIDTH;
         height_cfg_ff <= RESET_HEIGHT;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
      end
   end

   always_comb begin
      if (width_cfg_ff == '0) begin
         width_eff = CLW'(1);
      end else if (32'(width_cfg_ff) > MAX_WIDTH) begin
         width_eff = CLW'(MAX_WIDTH);
      end else begin
         width_eff = CLW'(width_cfg_ff);
      end
      if (height_cfg_ff == '0) begin
         height_eff = HW'(1);
      end else if (32'(height_cfg_ff) > MAX_HEIGHT) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(height_cfg_ff);
      end
   end

   assign lag = LAGW'(width_eff) * LAGW'(WINDOW_RADIUS) + LAGW'(WINDOW_RADIUS);

   bmec_front #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .WINDOW_RADIUS (WINDOW_RADIUS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .restart         (restart),
      .width           (width_eff),
      .height          (height_eff),
      .lag             (lag),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .job_push        (job_push),
      .job_data        (job_push_data),
      .job_full        (job_full),
      .drained         (drained)
   );

   bmec_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmec_fifo #(
      .WIDTH (JW),
      .DEPTH (2)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .pop_data  (job_pop_data),
      .full      (job_full),
      .empty     (job_empty)
   );

   bmec_back #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .WINDOW_RADIUS (WINDOW_RADIUS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .width          (width_eff),
      .height         (height_eff),
      .lag            (lag),
      .job_empty      (job_empty),
      .job_data       (job_pop_data),
      .job_pop        (job_pop),
      .idle           (back_idle),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_red   (rsp_mean_red),
      .rsp_mean_green (rsp_mean_green),
      .rsp_mean_blue  (rsp_mean_blue),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ----- tb/box_mean_5x5_edge_clipped_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_mean_5x5_edge_clipped_core_tb
// Streams frames of random RGB pixels through the box-mean core under random
// request gaps and response stalls. A scoreboard tracks its own copy of the
// geometry, pixel ring and positions, predicts every mean in order and checks
// each response transaction against it. Covers the reset geometry, zero and
// oversized sizes, early drains, late pixels, aborted frames and
// back-to-back frames.
// ----------------------------------------------------------------------------
module box_mean_5x5_edge_clipped_core_tb;
   import bmec_pkg::*;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int RADIUS      = 2;
   localparam int RING_DEPTH  = (2 * RADIUS + 2) * MAX_WIDTH;
   localparam int SETTLE_CYCLES = 80;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } mean_pixel_type;

   class box_mean_scoreboard;
      logic [CSR_W-1:0] width_reg;
      logic [CSR_W-1:0] height_reg;
      logic [PIX_W-1:0] pixel_ring [RING_DEPTH];
      int unsigned      in_row, in_col, out_row, out_col;
      mean_pixel_type   due_means[$];
      int               error_count;

      function new();
         width_reg   = RESET_WIDTH;
         height_reg  = RESET_HEIGHT;
         error_count = 0;
         restart();
      endfunction

      function void restart();
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return height_reg;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = data;
            restart();
         end else if (idx == CSR_IMAGE_HEIGHT) begin
            height_reg = data;
            restart();
         end
      endfunction

      function void take_pixel(logic op, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] b);
         int unsigned w, h, lag, lin, sr, sg, sb, cnt;
         int x, y;
         logic [PIX_W-1:0] px;
         mean_pixel_type m;
         w   = eff_width();
         h   = eff_height();
         lag = RADIUS * w + RADIUS;
         lin = in_row * w + in_col;
         if (in_row < h) pixel_ring[lin % RING_DEPTH] = (op == OP_DRAIN) ? '0 : {r, g, b};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (lin < lag) return;
         sr = 0; sg = 0; sb = 0; cnt = 0;
         for (int dr = -RADIUS; dr <= RADIUS; dr++) begin
            for (int dc = -RADIUS; dc <= RADIUS; dc++) begin
               x = int'(out_row) + dr;
               y = int'(out_col) + dc;
               if (x >= 0 && x < int'(h) && y >= 0 && y < int'(w)) begin
                  px = pixel_ring[(x * w + y) % RING_DEPTH];
                  sr += px[23:16];
                  sg += px[15:8];
                  sb += px[7:0];
                  cnt++;
               end
            end
         end
         m.red   = CHAN_W'(sr / cnt);
         m.green = CHAN_W'(sg / cnt);
         m.blue  = CHAN_W'(sb / cnt);
         m.last  = (out_row == h - 1) && (out_col == w - 1);
         due_means.push_back(m);
         if (m.last) restart();
         else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         error_count++;
      endtask

      task check_mean(mean_pixel_type got);
         mean_pixel_type want;
         if (due_means.size() == 0) begin
            report("response transaction with nothing due");
            return;
         end
         want = due_means.pop_front();
         if (got.red !== want.red)
            report($sformatf("red got %0d want %0d", got.red, want.red));
         if (got.green !== want.green)
            report($sformatf("green got %0d want %0d", got.green, want.green));
         if (got.blue !== want.blue)
            report($sformatf("blue got %0d want %0d", got.blue, want.blue));
         if (got.last !== want.last)
            report($sformatf("frame_last got %0b want %0b", got.last, want.last));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_operation = OP_PIXEL;
   logic [CHAN_W-1:0]    req_pixel_red = '0;
   logic [CHAN_W-1:0]    req_pixel_green = '0;
   logic [CHAN_W-1:0]    req_pixel_blue = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAN_W-1:0]    rsp_mean_red;
   logic [CHAN_W-1:0]    rsp_mean_green;
   logic [CHAN_W-1:0]    rsp_mean_blue;
   logic                 rsp_frame_last;

   box_mean_scoreboard tracker = new();
   bit                 burst_mode = 1'b0;
   int                 items_sent = 0;

   box_mean_5x5_edge_clipped_core #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WINDOW_RADIUS(RADIUS)
   ) u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_pixel_red(req_pixel_red), .req_pixel_green(req_pixel_green),
      .req_pixel_blue(req_pixel_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_mean_red(rsp_mean_red), .rsp_mean_green(rsp_mean_green),
      .rsp_mean_blue(rsp_mean_blue), .rsp_frame_last(rsp_frame_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("box_mean_5x5_edge_clipped_core_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      mean_pixel_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.red   = rsp_mean_red;
         got.green = rsp_mean_green;
         got.blue  = rsp_mean_blue;
         got.last  = rsp_frame_last;
         tracker.check_mean(got);
      end
   end

   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = burst_mode ? 0 : $urandom_range(0, 14);
         repeat (n) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_pixel(logic op, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_pixel_red   <= r;
      req_pixel_green <= g;
      req_pixel_blue  <= b;
      do @(posedge clock); while (req_stall);
      tracker.take_pixel(op, r, g, b);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.due_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic set_geometry(logic [CSR_W-1:0] w, logic [CSR_W-1:0] h);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   // pixels first with a few early drains, then the flush tail with late pixels
   task automatic play_frame(int n_items);
      int pixels;
      logic op;
      pixels = tracker.eff_width() * tracker.eff_height();
      for (int i = 0; i < n_items; i++) begin
         if (i < pixels) op = ($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL;
         else op = ($urandom_range(0, 2) == 0) ? OP_PIXEL : OP_DRAIN;
         send_pixel(op, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
      end
   endtask

   function automatic int frame_items();
      return tracker.eff_width() * tracker.eff_height() +
             RADIUS * tracker.eff_width() + RADIUS;
   endfunction

   initial begin
      int n;
      logic [CHAN_W-1:0] v;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: a few pixels, no result yet
      for (int i = 0; i < 4; i++) send_pixel(OP_PIXEL, 8'hFF, 8'h00, 8'hA5);

      // zero sizes clamp to one pixel
      set_geometry(12'd0, 12'd0);
      send_pixel(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 4; i++) send_pixel(OP_PIXEL, 8'h00, 8'h00, 8'h00);

      set_geometry(12'd5, 12'd3);
      for (int i = 0; i < 27; i++) begin
         v = (i % 3 == 0) ? 8'hFF : 8'h00;
         if (i == 7) send_pixel(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
         else if (i == 20) send_pixel(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
         else if (i >= 15) send_pixel(OP_DRAIN, 8'h55, 8'hAA, 8'h0F);
         else send_pixel(OP_PIXEL, v, ~v, 8'(i * 17));
      end

      while (items_sent < 560) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         wait_idle();
         if ($urandom_range(0, 9) == 0)
            write_csr(CSR_IDX_W'($urandom_range(2, 3)), CSR_W'($urandom));
         write_csr(CSR_IMAGE_WIDTH, ($urandom_range(0, 15) == 0) ? 12'd0 :
                   CSR_W'($urandom_range(1, 12)));
         write_csr(CSR_IMAGE_HEIGHT, ($urandom_range(0, 15) == 0) ? 12'd0 :
                   CSR_W'($urandom_range(1, 8)));
         if ($urandom_range(0, 6) == 0) begin
            n = frame_items();
            play_frame($urandom_range(1, n > 1 ? n - 1 : 1));
         end else begin
            repeat ($urandom_range(1, 2)) play_frame(frame_items());
         end
      end

      // oversized height, start of the frame only
      burst_mode = 1'b0;
      set_geometry(12'd1, 12'hFFF);
      play_frame(80);

      wait_idle();
      if (tracker.error_count == 0) begin
         $display("box_mean_5x5_edge_clipped_core_tb: clean");
      end else begin
         $display("box_mean_5x5_edge_clipped_core_tb: errors");
      end
      $finish;
   end

endmodule

// ----- box_mean_5x5_edge_clipped_core.f -----
hw/rtl/bmec_pkg.sv
hw/rtl/bmec_ram.sv
hw/rtl/bmec_fifo.sv
hw/rtl/bmec_front.sv
hw/rtl/bmec_back.sv
hw/rtl/box_mean_5x5_edge_clipped_core.sv
tb/box_mean_5x5_edge_clipped_core_tb.sv
